// ----- rtl/assert_macros.svh -----
// Assertion macros for the time unit converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define TUC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define TUC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tuc_pkg.sv -----
// Types, unit weights and ratio table for the time unit converter.
package tuc_pkg;

  localparam int UNIT_W  = 3;
  localparam int DATA_W  = 64;
  localparam int RATIO_W = 47;
  localparam int REM_W   = RATIO_W + 1;
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES = DATA_W / BITS_PER_STAGE;

  typedef logic [UNIT_W-1:0]  unit_t;
  typedef logic [RATIO_W-1:0] ratio_t;

  localparam unit_t UNIT_NS  = 3'd0;
  localparam unit_t UNIT_US  = 3'd1;
  localparam unit_t UNIT_MS  = 3'd2;
  localparam unit_t UNIT_S   = 3'd3;
  localparam unit_t UNIT_MIN = 3'd4;
  localparam unit_t UNIT_H   = 3'd5;
  localparam unit_t UNIT_DAY = 3'd6;

  localparam logic [63:0] W_NS  = 64'd1;
  localparam logic [63:0] W_US  = 64'd1000;
  localparam logic [63:0] W_MS  = 64'd1000000;
  localparam logic [63:0] W_S   = 64'd1000000000;
  localparam logic [63:0] W_MIN = 64'd60000000000;
  localparam logic [63:0] W_H   = 64'd3600000000000;
  localparam logic [63:0] W_DAY = 64'd86400000000000;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // One pipeline stage of the conversion.
  typedef struct packed {
    logic                mul;
    logic                neg;
    ratio_t              ratio;
    logic [REM_W-1:0]    rem;
    logic [DATA_W-1:0]   quo;
    logic [DATA_W-1:0]   res;
  } stage_t;

  // Map the unused code seven onto days.
  function automatic unit_t clamp_unit(input unit_t code);
    clamp_unit = (code == 3'd7) ? UNIT_DAY : code;
  endfunction

  function automatic logic [63:0] unit_weight(input unit_t u);
    logic [63:0] w;
    w = W_DAY;
    unique case (u)
      UNIT_NS:  w = W_NS;
      UNIT_US:  w = W_US;
      UNIT_MS:  w = W_MS;
      UNIT_S:   w = W_S;
      UNIT_MIN: w = W_MIN;
      UNIT_H:   w = W_H;
      default:  w = W_DAY;
    endcase
    unit_weight = w;
  endfunction

  // Weight of the coarse unit over the fine unit (coarse >= fine).
  localparam logic [63:0] R_DAY_H   = W_DAY / W_H;
  localparam logic [63:0] R_DAY_MIN = W_DAY / W_MIN;
  localparam logic [63:0] R_DAY_S   = W_DAY / W_S;
  localparam logic [63:0] R_DAY_MS  = W_DAY / W_MS;
  localparam logic [63:0] R_DAY_US  = W_DAY / W_US;
  localparam logic [63:0] R_H_MIN   = W_H / W_MIN;
  localparam logic [63:0] R_H_S     = W_H / W_S;
  localparam logic [63:0] R_H_MS    = W_H / W_MS;
  localparam logic [63:0] R_H_US    = W_H / W_US;
  localparam logic [63:0] R_MIN_S   = W_MIN / W_S;
  localparam logic [63:0] R_MIN_MS  = W_MIN / W_MS;
  localparam logic [63:0] R_MIN_US  = W_MIN / W_US;
  localparam logic [63:0] R_S_MS    = W_S / W_MS;
  localparam logic [63:0] R_S_US    = W_S / W_US;
  localparam logic [63:0] R_MS_US   = W_MS / W_US;

  function automatic ratio_t unit_ratio(input unit_t coarse, input unit_t fine);
    logic [63:0] r;
    r = 64'd1;
    if (fine == UNIT_NS) begin
      r = unit_weight(coarse);
    end else if (coarse == fine) begin
      r = 64'd1;
    end else begin
      unique case ({coarse, fine})
        {UNIT_DAY, UNIT_H}:   r = R_DAY_H;
        {UNIT_DAY, UNIT_MIN}: r = R_DAY_MIN;
        {UNIT_DAY, UNIT_S}:   r = R_DAY_S;
        {UNIT_DAY, UNIT_MS}:  r = R_DAY_MS;
        {UNIT_DAY, UNIT_US}:  r = R_DAY_US;
        {UNIT_H, UNIT_MIN}:   r = R_H_MIN;
        {UNIT_H, UNIT_S}:     r = R_H_S;
        {UNIT_H, UNIT_MS}:    r = R_H_MS;
        {UNIT_H, UNIT_US}:    r = R_H_US;
        {UNIT_MIN, UNIT_S}:   r = R_MIN_S;
        {UNIT_MIN, UNIT_MS}:  r = R_MIN_MS;
        {UNIT_MIN, UNIT_US}:  r = R_MIN_US;
        {UNIT_S, UNIT_MS}:    r = R_S_MS;
        {UNIT_S, UNIT_US}:    r = R_S_US;
        {UNIT_MS, UNIT_US}:   r = R_MS_US;
        default:              r = 64'd1;
      endcase
    end
    unit_ratio = r[RATIO_W-1:0];
  endfunction

endpackage

// ----- rtl/time_unit_converter_unit.sv -----
// Top level of the time unit converter: input decode, divider pipeline, output stage.
//
// Converts a signed 64-bit duration from one of seven units (ns, us, ms, s,
// min, h, day; code seven reads as day) to another. Toward a finer unit the
// count is multiplied by the weight ratio and saturates to the signed 64-bit
// limits; toward a coarser unit it is divided and truncated toward zero.
// Input channel: in_valid/in_ready with in_duration, in_source_unit and
// in_target_unit. Result channel: out_valid/out_ready with out_converted.
// Every transfer gives exactly one result, in order.
// The pipeline is one decode stage, sixteen restoring-divider stages of four
// quotient bits each (the multiply path runs beside the divider and loads its
// product into the third), and the output register.
// Throughput is one item per cycle unless the output stalls; the sixteen
// divider stages set the depth. While a result waits on the receiver, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated. Reset (rst_n low,
// synchronous) empties the pipeline; no item is in flight after it.
module time_unit_converter_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [63:0]        in_duration,
  input  logic [2:0]                in_source_unit,
  input  logic [2:0]                in_target_unit,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [63:0]        out_converted
);

`include "assert_macros.svh"

  localparam int NS = tuc_pkg::DIV_STAGES;
  localparam int BS = tuc_pkg::BITS_PER_STAGE;

  tuc_pkg::stage_t  p_r   [NS+1];
  tuc_pkg::stage_t  p_nxt [NS+1];
  logic [NS:0]      vld_r;
  logic             en;
  logic             out_valid_r;
  logic [63:0]      out_converted_r;
  logic [63:0]      mul_res;

  tuc_pkg::unit_t   su, tu;
  logic             dec_mul;

  // Four restoring division steps on one stage.
  function automatic tuc_pkg::stage_t div_step(input tuc_pkg::stage_t s);
    tuc_pkg::stage_t  o;
    logic [tuc_pkg::REM_W-1:0] r;
    o = s;
    for (int i = 0; i < BS; i++) begin
      r     = {o.rem[tuc_pkg::REM_W-2:0], o.quo[tuc_pkg::DATA_W-1]};
      o.quo = {o.quo[tuc_pkg::DATA_W-2:0], 1'b0};
      if (r >= {1'b0, o.ratio}) begin
        r        = r - {1'b0, o.ratio};
        o.quo[0] = 1'b1;
      end
      o.rem = r;
    end
    div_step = o;
  endfunction

  // Advance the whole pipeline unless the result waits.
  assign en       = out_ready || !out_valid_r;
  assign in_ready = en;

  // Decode units, ratio and magnitude, then run the divider stages.
  always_comb begin
    su      = tuc_pkg::clamp_unit(in_source_unit);
    tu      = tuc_pkg::clamp_unit(in_target_unit);
    dec_mul = (su >= tu);
    p_nxt[0].mul   = dec_mul;
    p_nxt[0].neg   = in_duration[63];
    p_nxt[0].ratio = dec_mul ? tuc_pkg::unit_ratio(su, tu) : tuc_pkg::unit_ratio(tu, su);
    p_nxt[0].rem   = '0;
    p_nxt[0].quo   = in_duration[63] ? (~in_duration + 64'd1) : in_duration;
    p_nxt[0].res   = '0;
    // Divider stages; load the product beside the third stage.
    for (int k = 1; k <= NS; k++) begin
      p_nxt[k] = div_step(p_r[k-1]);
      if (k == 3) begin
        p_nxt[k].res = mul_res;
      end
    end
  end

  tuc_mul u_mul (
    .clk   (clk),
    .en    (en),
    .mag   (p_r[0].quo),
    .ratio (p_r[0].ratio),
    .neg   (p_r[0].neg),
    .res   (mul_res)
  );

  // Hold stage payload on stall.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= NS; k++) begin
        p_r[k] <= p_nxt[k];
      end
    end
  end

  // Move valid bits with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NS-1:0], in_valid};
      out_valid_r <= vld_r[NS];
    end
  end

  // Select the product or the signed quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      if (p_r[NS].mul) begin
        out_converted_r <= p_r[NS].res;
      end else begin
        out_converted_r <= p_r[NS].neg ? (~p_r[NS].quo + 64'd1) : p_r[NS].quo;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_converted = out_converted_r;

  `TUC_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid_r |-> in_ready, "in_ready low with empty output")
  `TUC_ASSERT(a_enter_stage0, clk, rst_n, (in_valid && in_ready) |=> vld_r[0], "transfer did not enter pipeline")
  `TUC_ASSERT(a_mul_sign, clk, rst_n, (vld_r[NS] && p_r[NS].mul && !p_r[NS].neg) |-> !p_r[NS].res[63], "positive product went negative")
  `TUC_ASSERT(a_quo_range, clk, rst_n, (vld_r[NS] && !p_r[NS].mul) |-> (p_r[NS].quo[63:59] == 5'd0), "quotient out of range")
  `TUC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

// ----- rtl/tuc_mul.sv -----
// Two-stage saturating multiply of a magnitude by a unit ratio.
module tuc_mul (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tuc_pkg::DATA_W-1:0] mag,
  input  tuc_pkg::ratio_t           ratio,
  input  logic                      neg,
  output logic [tuc_pkg::DATA_W-1:0] res
);

  localparam int HW = 32;
  localparam int RH = tuc_pkg::RATIO_W - HW;
  localparam int PW = tuc_pkg::DATA_W + tuc_pkg::RATIO_W;

  logic [2*HW-1:0]   pp_ll_r, pp_hl_r;
  logic [HW+RH-1:0]  pp_lh_r, pp_hh_r;
  logic              neg_a_r, neg_b_r;
  logic [PW-1:0]     sum_r;
  logic              sat;

  // Form four partial products of at most 32 x 32 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= mag[HW-1:0] * ratio[HW-1:0];
      pp_lh_r <= mag[HW-1:0] * ratio[tuc_pkg::RATIO_W-1:HW];
      pp_hl_r <= mag[2*HW-1:HW] * ratio[HW-1:0];
      pp_hh_r <= mag[2*HW-1:HW] * ratio[tuc_pkg::RATIO_W-1:HW];
      neg_a_r <= neg;
    end
  end

  // Sum the partial products into the exact product.
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= PW'(pp_ll_r)
               + (PW'(pp_lh_r) << HW)
               + (PW'(pp_hl_r) << HW)
               + (PW'(pp_hh_r) << (2*HW));
      neg_b_r <= neg_a_r;
    end
  end

  // Saturate and apply the sign.
  always_comb begin
    if (neg_b_r) begin
      sat = (|sum_r[PW-1:64]) || (sum_r[63] && (|sum_r[62:0]));
      res = sat ? tuc_pkg::SAT_MIN : (~sum_r[63:0] + 64'd1);
    end else begin
      sat = |sum_r[PW-1:63];
      res = sat ? tuc_pkg::SAT_MAX : sum_r[63:0];
    end
  end

endmodule
